// ----- hdl/assert_macros.svh -----
// Assertion helper macros shared by the Playfair encryptor RTL.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define PF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pf check failed: same-cycle implication");

// Next-cycle implication, checked while out of reset
`define PF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pf check failed: next-cycle implication");

`endif

// ----- hdl/pf_pkg.sv -----
// Shared types, constants and helper functions for the Playfair encryptor.
// No dependencies; imported by every module of the block.
`default_nettype none

package pf_pkg;

  localparam int GRID_SIZE      = 5;
  localparam int PF_QUEUE_DEPTH = 4;

  typedef logic [4:0] letter_t;
  typedef letter_t [GRID_SIZE-1:0] row_t;
  typedef row_t [GRID_SIZE-1:0] square_t;
  typedef logic [2:0] pos_t;

  typedef struct packed {
    pos_t row;
    pos_t col;
  } loc_t;

  // One letter pair handed from front to back
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } pair_t;

  // Letter indices, A = 0
  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;

  // ASCII ranges
  localparam logic [7:0] ASCII_UP_A  = 8'd65;
  localparam logic [7:0] ASCII_UP_Z  = 8'd90;
  localparam logic [7:0] ASCII_LOW_A = 8'd97;
  localparam logic [7:0] ASCII_LOW_Z = 8'd122;
  localparam logic [6:0] ASCII_OUT_A = 7'd65;

  // Configuration register indexes
  localparam logic [2:0] REG_SQUARE_ROW_0 = 3'd0;
  localparam logic [2:0] REG_SQUARE_ROW_1 = 3'd1;
  localparam logic [2:0] REG_SQUARE_ROW_2 = 3'd2;
  localparam logic [2:0] REG_SQUARE_ROW_3 = 3'd3;
  localparam logic [2:0] REG_SQUARE_ROW_4 = 3'd4;

  // First row-major match; row 0 column 0 when absent
  function automatic loc_t locate(input letter_t letter, input square_t sq);
    loc_t found;
    found = '0;
    for (int r = GRID_SIZE - 1; r >= 0; r--) begin
      for (int c = GRID_SIZE - 1; c >= 0; c--) begin
        if (sq[r][c] == letter) begin
          found.row = pos_t'(r);
          found.col = pos_t'(c);
        end
      end
    end
    return found;
  endfunction

  // Step one row or column with wrap
  function automatic pos_t next_pos(input pos_t p);
    return (p == pos_t'(GRID_SIZE - 1)) ? pos_t'(0) : pos_t'(p + 3'd1);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/playfair_digraph_encrypt.sv -----
// Playfair digraph encryptor, top level: square registers and wiring.
// Depends on pf_pkg, pf_front, pf_queue and pf_back.
//
// Usage:
//   Input stream (in_*): one plaintext byte per request, in_tlast on the
//   last byte of a message. Non-letters are dropped, case is folded, J -> I.
//   Output stream (out_*): one uppercase cipher letter per request,
//   out_tlast on the final letter of a message.
//   Square: write rows 0..4 via cfg_we/cfg_index/cfg_wdata while idle;
//   column 0 sits in bits 4..0 of each row.
//   A completed pair passes through the queue, stage 1 (pair register),
//   stage 2 (located pair) and the output register; the second letter
//   follows the first from stage 2. Throughput: the back end sends one
//   letter per cycle while out_tready is high, two per pair; a doubled
//   final letter yields two pairs, in_tready low till the second is queued.
//   Reset clears the held letter, the queue, the pipeline and the square.
//   An output stall backs up through the pair queue (PF_QUEUE_DEPTH pairs)
//   before in_tready drops; no request is lost or repeated.
`default_nettype none

module playfair_digraph_encrypt
  import pf_pkg::*;
#(
  parameter int QueueDepth = PF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [6:0] cipher_letter, [7] zero
  output logic             out_tlast,  // last_letter
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata
);

  square_t square_r;
  logic    q_push, q_full, q_pop, q_empty;
  pair_t   q_in, q_head;

  // Square row registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SQUARE_ROW_0: square_r[0] <= cfg_wdata;
        REG_SQUARE_ROW_1: square_r[1] <= cfg_wdata;
        REG_SQUARE_ROW_2: square_r[2] <= cfg_wdata;
        REG_SQUARE_ROW_3: square_r[3] <= cfg_wdata;
        REG_SQUARE_ROW_4: square_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  pf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .square     (square_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/pf_front.sv -----
// Front end: filters and folds text bytes, pairs letters, splits doubles.
// Depends on pf_pkg; feeds pairs into pf_queue.
`default_nettype none
`include "assert_macros.svh"

module pf_front
  import pf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,   // end_of_text
  input  wire logic       q_full,
  output logic            q_push,
  output pair_t           q_data
);

  logic    held_v_r, held_v_nxt;
  letter_t held_r, held_nxt;
  logic    sec_v_r, sec_v_nxt;
  pair_t   sec_r, sec_nxt;

  logic    accept;
  logic    is_letter;
  letter_t letter;
  logic    p1_v, p2_v;
  pair_t   p1, p2;

  assign in_tready = !sec_v_r && !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify the byte: fold case, J reads as I
  always_comb begin
    is_letter = 1'b1;
    letter    = '0;
    if (in_tdata >= ASCII_UP_A && in_tdata <= ASCII_UP_Z) begin
      letter = letter_t'(in_tdata - ASCII_UP_A);
    end else if (in_tdata >= ASCII_LOW_A && in_tdata <= ASCII_LOW_Z) begin
      letter = letter_t'(in_tdata - ASCII_LOW_A);
    end else begin
      is_letter = 1'b0;
    end
    if (letter == LETTER_J) begin
      letter = LETTER_I;
    end
  end

  // Pairing and end-of-text flush
  always_comb begin
    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    p1_v       = 1'b0;
    p2_v       = 1'b0;
    p1         = '0;
    p2         = '0;
    if (is_letter) begin
      if (!held_v_r) begin
        held_nxt   = letter;
        held_v_nxt = 1'b1;
      end else if (held_r == letter) begin
        p1_v = 1'b1;
        p1   = '{a: held_r, b: LETTER_X, last: 1'b0};
      end else begin
        p1_v       = 1'b1;
        p1         = '{a: held_r, b: letter, last: 1'b0};
        held_v_nxt = 1'b0;
        held_nxt   = '0;
      end
    end
    if (in_tlast) begin
      if (held_v_nxt) begin
        if (p1_v) begin
          p2_v = 1'b1;
          p2   = '{a: held_nxt, b: LETTER_X, last: 1'b1};
        end else begin
          p1_v = 1'b1;
          p1   = '{a: held_nxt, b: LETTER_X, last: 1'b1};
        end
      end else begin
        p1.last = 1'b1;
      end
      held_v_nxt = 1'b0;
      held_nxt   = '0;
    end
  end

  // Queue write: a parked second pair goes first
  always_comb begin
    q_push    = 1'b0;
    q_data    = p1;
    sec_v_nxt = sec_v_r;
    sec_nxt   = sec_r;
    if (sec_v_r) begin
      q_data = sec_r;
      if (!q_full) begin
        q_push    = 1'b1;
        sec_v_nxt = 1'b0;
      end
    end else if (accept) begin
      q_push = p1_v;
      if (p2_v) begin
        sec_v_nxt = 1'b1;
        sec_nxt   = p2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      held_r   <= '0;
      sec_v_r  <= 1'b0;
    end else begin
      sec_v_r <= sec_v_nxt;
      if (accept) begin
        held_v_r <= held_v_nxt;
        held_r   <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    sec_r <= sec_nxt;
  end

  // A parked second pair only comes from a flush, so nothing is held
  `PF_ASSERT_IMPL(a_front_sec_no_held, clk, rst_n, sec_v_r, !held_v_r)

endmodule

`default_nettype wire

// ----- hdl/pf_queue.sv -----
// Short pair queue that decouples the front end from the cipher back end.
// Depends on pf_pkg for the pair type.
`default_nettype none
`include "assert_macros.svh"

module pf_queue
  import pf_pkg::*;
#(
  parameter int Depth = PF_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire pair_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output pair_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pair_t             mem [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;

  assign full  = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= CntW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CntW'(count_r - 1'b1);
      end
    end
  end

  `PF_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, push, !full || pop)
  `PF_ASSERT_NEXT(a_q_grow, clk, rst_n, rst_n && push && !pop,
                  count_r == CntW'($past(count_r) + 1'b1))

endmodule

`default_nettype wire

// ----- hdl/pf_back.sv -----
// Back end: locates each pair in the square, applies the Playfair rules
// and sends the two cipher letters. Depends on pf_pkg.
`default_nettype none
`include "assert_macros.svh"

module pf_back
  import pf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire square_t    square,
  input  wire logic       q_empty,
  input  wire pair_t      q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] cipher_letter, [7] zero
  output logic            out_tlast   // last_letter
);

  // Stage 1: pair from the queue
  logic  pair_v_r;
  pair_t pair_r;
  // Stage 2: located pair
  logic  loc_v_r;
  loc_t  loc_a_r, loc_b_r;
  logic  loc_last_r;
  logic  phase_r;
  // Output register
  logic       out_v_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic    out_load, loc_done, loc_free, pair_adv, pair_free;
  loc_t    la, lb;
  letter_t ea, eb, sel;

  assign out_load  = loc_v_r && (!out_v_r || out_tready);
  assign loc_done  = out_load && phase_r;
  assign loc_free  = !loc_v_r || loc_done;
  assign pair_adv  = pair_v_r && loc_free;
  assign pair_free = !pair_v_r || pair_adv;
  assign q_pop     = !q_empty && pair_free;

  assign la = locate(pair_r.a, square);
  assign lb = locate(pair_r.b, square);

  // Playfair rules on the located pair
  always_comb begin
    if (loc_a_r.row == loc_b_r.row) begin
      ea = square[loc_a_r.row][next_pos(loc_a_r.col)];
      eb = square[loc_b_r.row][next_pos(loc_b_r.col)];
    end else if (loc_a_r.col == loc_b_r.col) begin
      ea = square[next_pos(loc_a_r.row)][loc_a_r.col];
      eb = square[next_pos(loc_b_r.row)][loc_b_r.col];
    end else begin
      ea = square[loc_a_r.row][loc_b_r.col];
      eb = square[loc_b_r.row][loc_a_r.col];
    end
    sel = phase_r ? eb : ea;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_v_r <= 1'b0;
      loc_v_r  <= 1'b0;
      phase_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (pair_free) begin
        pair_v_r <= q_pop;
      end
      if (loc_free) begin
        loc_v_r <= pair_adv;
      end
      if (out_load) begin
        phase_r <= !phase_r;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pair_r <= q_head;
    end
    if (pair_adv) begin
      loc_a_r    <= la;
      loc_b_r    <= lb;
      loc_last_r <= pair_r.last;
    end
    if (out_load) begin
      out_data_r <= {1'b0, 7'(ASCII_OUT_A + {2'b00, sel})};
      out_last_r <= phase_r && loc_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Second letter is only sent while its pair still sits in stage 2
  `PF_ASSERT_IMPL(a_back_phase_live, clk, rst_n, phase_r, loc_v_r)

endmodule

`default_nettype wire
